// File: src/qslerp_pkg.sv
package qslerp_pkg;

	localparam int COMP_WIDTH_DEF = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int IFRAC = 30;
	localparam int THR_WIDTH = 15;
	localparam int THR_FRAC = 14;
	localparam logic [THR_WIDTH-1:0] THR_RESET = 15'd16382;
	localparam logic signed [47:0] ONE_Q30 = 48'sd1073741824;
	localparam logic signed [47:0] INV_GAIN_Q30 = 48'sd652032874;
	localparam logic signed [47:0] K_MAX = 48'sd2147483647;

	// arctangent of 2^-i in q.30
	function automatic logic signed [47:0] atan_step(input int i);
		logic signed [47:0] r;
		r = '0;
		unique case (i)
			0: r = 48'sd843314857;
			1: r = 48'sd497837829;
			2: r = 48'sd263043837;
			3: r = 48'sd133525159;
			4: r = 48'sd67021687;
			5: r = 48'sd33543516;
			6: r = 48'sd16775851;
			7: r = 48'sd8388437;
			8: r = 48'sd4194283;
			9: r = 48'sd2097149;
			10: r = 48'sd1048576;
			default: r = (i <= IFRAC) ? (48'sd1 <<< (IFRAC - i)) : 48'sd0;
		endcase
		return r;
	endfunction

endpackage

// File: src/qslerp_pipe.sv
// generic stage holder with data and valid, used for most stages
module qslerp_pipe #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vin,
	input  logic [W-1:0] din,
	output logic         vout,
	output logic [W-1:0] dout
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= din;
		end
	end
endmodule

// File: src/quaternion_slerp_unit.sv
// Quaternion slerp: takes one item (two Q1.14 quaternions plus a Q1.15 blend) per cycle
// while the pipe is not stalled and returns the blended quaternion, fully pipelined. Its
// stages are: products (1), dot and sign fix (1), c*c (1), square root (31, one root
// bit per stage), cordic vectoring (CORDIC_STAGES), angle scaling (1), two
// cordic sines in parallel (CORDIC_STAGES), weight divide (31, one quotient bit per stage),
// mix (1), round and saturate into the output register (1). Every stage moves on the same
// enable, so a stall on the output freezes the whole pipe; in_stall is high exactly when
// a finished item waits on out_stall. The threshold register takes a write in any cycle
// but should only change while no item is in flight. linear_path flags the linear weights.
module quaternion_slerp_unit #(
	parameter int COMP_WIDTH = qslerp_pkg::COMP_WIDTH_DEF,
	parameter int CORDIC_STAGES = qslerp_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [qslerp_pkg::THR_WIDTH-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COMP_WIDTH-1:0] first_w,
	input  logic signed [COMP_WIDTH-1:0] first_x,
	input  logic signed [COMP_WIDTH-1:0] first_y,
	input  logic signed [COMP_WIDTH-1:0] first_z,
	input  logic signed [COMP_WIDTH-1:0] second_w,
	input  logic signed [COMP_WIDTH-1:0] second_x,
	input  logic signed [COMP_WIDTH-1:0] second_y,
	input  logic signed [COMP_WIDTH-1:0] second_z,
	input  logic [COMP_WIDTH-1:0] blend,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [COMP_WIDTH-1:0] out_w,
	output logic signed [COMP_WIDTH-1:0] out_x,
	output logic signed [COMP_WIDTH-1:0] out_y,
	output logic signed [COMP_WIDTH-1:0] out_z,
	output logic linear_path
);
	localparam int CW = COMP_WIDTH;
	localparam int F = CW - 2;
	localparam int SQ = 31;          // sqrt result bits (radicand <= 2^60)
	localparam int DV = 31;          // quotient bits of the weight divide
	// internal signed width: covers the mix sum a*k0 + b*k1 plus rounding
	localparam int L = (CW + 34 > 48) ? CW + 34 : 48;

	typedef logic signed [L-1:0] w_t;
	typedef logic signed [CW-1:0] c_t;
	typedef logic signed [CW:0] b_t;

	localparam w_t ONE = L'(qslerp_pkg::ONE_Q30);
	localparam w_t INV_GAIN = L'(qslerp_pkg::INV_GAIN_Q30);
	localparam w_t KMAX = L'(qslerp_pkg::K_MAX);

	logic [qslerp_pkg::THR_WIDTH-1:0] thr_q;
	logic en;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qslerp_pkg::THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// global enable: pipe advances unless a finished item is held
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// per-item context carried along the whole pipe
	// b is one bit wider so that negating the most negative component cannot wrap
	typedef struct packed {
		c_t [3:0] a;
		b_t [3:0] b;
		w_t t30;
		logic lin;
		w_t c;
		w_t s;
	} ctx_t;

	// ---------- stage 1: products ----------
	logic v1;
	w_t [3:0] prod_s1;
	c_t [3:0] a_s1, b_s1;
	logic [CW-1:0] bl_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1 <= 1'b0;
		else if (en) v1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= {first_z, first_y, first_x, first_w};
			b_s1 <= {second_z, second_y, second_x, second_w};
			prod_s1[0] <= L'(first_w) * L'(second_w);
			prod_s1[1] <= L'(first_x) * L'(second_x);
			prod_s1[2] <= L'(first_y) * L'(second_y);
			prod_s1[3] <= L'(first_z) * L'(second_z);
			bl_s1 <= blend;
		end
	end

	// ---------- stage 2: dot, sign fix, linear test, c ----------
	w_t acc, dot, dabs, dmin, c_n;
	logic lin_n;
	logic [CW-1:0] tb;
	ctx_t ctx2_n;
	always_comb begin
		acc = (prod_s1[0] >>> 2) + (prod_s1[1] >>> 2) + (prod_s1[2] >>> 2)
			+ (prod_s1[3] >>> 2);
		dot = acc >>> (F - 2);
		ctx2_n.a = a_s1;
		dabs = dot;
		if (dot < 0) dabs = -dot;
		// negative dot: flip the second quaternion onto the short arc
		for (int i = 0; i < 4; i++) begin
			ctx2_n.b[i] = (CW+1)'(b_s1[i]);
			if (dot < 0) ctx2_n.b[i] = -((CW+1)'(b_s1[i]));
		end
		tb = bl_s1;
		if (tb > (CW'(1) << (CW - 1))) tb = CW'(1) << (CW - 1);
		ctx2_n.t30 = (L'(tb) <<< qslerp_pkg::IFRAC) >>> (CW - 1);
		lin_n = (dabs <<< qslerp_pkg::THR_FRAC) > (L'(thr_q) <<< F);
		dmin = (dabs > (L'(1) <<< F)) ? (L'(1) <<< F) : dabs;
		c_n = (dmin <<< qslerp_pkg::IFRAC) >>> F;
		ctx2_n.lin = lin_n;
		ctx2_n.c = c_n;
		ctx2_n.s = '0;
	end
	logic v2;
	ctx_t ctx_s2;
	qslerp_pipe #(.W($bits(ctx_t))) u_s2 (.clk, .arst_n, .en, .vin(v1),
		.din(ctx2_n), .vout(v2), .dout(ctx_s2));

	// ---------- stage 3: c*c ----------
	logic v3;
	ctx_t ctx_s3;
	logic [63:0] cc_s3;
	always_ff @(posedge clk) begin
		if (en) cc_s3 <= 64'(ctx_s2.c[31:0]) * 64'(ctx_s2.c[31:0]);
	end
	qslerp_pipe #(.W($bits(ctx_t))) u_s3 (.clk, .arst_n, .en, .vin(v2),
		.din(ctx_s2), .vout(v3), .dout(ctx_s3));

	// ---------- sqrt pipeline: one result bit per stage ----------
	typedef struct packed {
		ctx_t x;
		logic [63:0] rem;
		logic [63:0] root;
	} sq_t;
	sq_t sq_in;
	sq_t [SQ:0] sqd;
	logic [SQ:0] sqv;
	always_comb begin
		sq_in.x = ctx_s3;
		sq_in.rem = 64'((ONE - L'(cc_s3 >> qslerp_pkg::IFRAC))) << qslerp_pkg::IFRAC;
		sq_in.root = '0;
	end
	assign sqd[0] = sq_in;
	assign sqv[0] = v3;
	for (genvar g = 0; g < SQ; g++) begin : g_sq
		sq_t nx;
		logic [63:0] trial;
		always_comb begin
			nx = sqd[g];
			trial = (sqd[g].root << 2) | 64'd1;
			trial = trial << (2 * (SQ - 1 - g));
			nx.root = sqd[g].root << 1;
			if (sqd[g].rem >= trial) begin
				nx.rem = sqd[g].rem - trial;
				nx.root = (sqd[g].root << 1) | 64'd1;
			end
		end
		qslerp_pipe #(.W($bits(sq_t))) u_p (.clk, .arst_n, .en, .vin(sqv[g]),
			.din(nx), .vout(sqv[g+1]), .dout(sqd[g+1]));
	end

	// ---------- cordic vectoring ----------
	typedef struct packed {
		ctx_t x;
		w_t vx;
		w_t vy;
		w_t z;
	} cv_t;
	cv_t cv_in;
	cv_t [CORDIC_STAGES:0] cvd;
	logic [CORDIC_STAGES:0] cvv;
	always_comb begin
		cv_in.x = sqd[SQ].x;
		cv_in.x.s = L'(sqd[SQ].root);
		// zero sine falls back to the linear weights
		if (sqd[SQ].root == 64'd0) cv_in.x.lin = 1'b1;
		cv_in.vx = sqd[SQ].x.c;
		cv_in.vy = L'(sqd[SQ].root);
		cv_in.z = '0;
	end
	assign cvd[0] = cv_in;
	assign cvv[0] = sqv[SQ];
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cv
		cv_t nx;
		always_comb begin
			nx = cvd[g];
			if (cvd[g].vy > 0) begin
				nx.vx = cvd[g].vx + (cvd[g].vy >>> g);
				nx.vy = cvd[g].vy - (cvd[g].vx >>> g);
				nx.z = cvd[g].z + L'(qslerp_pkg::atan_step(g));
			end else begin
				nx.vx = cvd[g].vx - (cvd[g].vy >>> g);
				nx.vy = cvd[g].vy + (cvd[g].vx >>> g);
				nx.z = cvd[g].z - L'(qslerp_pkg::atan_step(g));
			end
		end
		qslerp_pipe #(.W($bits(cv_t))) u_p (.clk, .arst_n, .en, .vin(cvv[g]),
			.din(nx), .vout(cvv[g+1]), .dout(cvd[g+1]));
	end

	// ---------- angle scaling ----------
	typedef struct packed {
		ctx_t x;
		w_t z0;
		w_t z1;
	} an_t;
	an_t an_n, an_s;
	logic van;
	always_comb begin
		an_n.x = cvd[CORDIC_STAGES].x;
		an_n.z0 = L'(((64'(ONE - cvd[CORDIC_STAGES].x.t30))
			* 64'(cvd[CORDIC_STAGES].z)) >>> qslerp_pkg::IFRAC);
		an_n.z1 = L'((64'(cvd[CORDIC_STAGES].x.t30) * 64'(cvd[CORDIC_STAGES].z))
			>>> qslerp_pkg::IFRAC);
	end
	qslerp_pipe #(.W($bits(an_t))) u_an (.clk, .arst_n, .en, .vin(cvv[CORDIC_STAGES]),
		.din(an_n), .vout(van), .dout(an_s));

	// ---------- two cordic rotations in parallel ----------
	typedef struct packed {
		ctx_t x;
		w_t [1:0] rx;
		w_t [1:0] ry;
		w_t [1:0] rz;
	} cr_t;
	cr_t cr_in;
	cr_t [CORDIC_STAGES:0] crd;
	logic [CORDIC_STAGES:0] crv;
	always_comb begin
		cr_in.x = an_s.x;
		cr_in.rx = {INV_GAIN, INV_GAIN};
		cr_in.ry = '0;
		cr_in.rz = {an_s.z1, an_s.z0};
	end
	assign crd[0] = cr_in;
	assign crv[0] = van;
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cr
		cr_t nx;
		always_comb begin
			nx = crd[g];
			for (int j = 0; j < 2; j++) begin
				if (crd[g].rz[j] >= 0) begin
					nx.rx[j] = crd[g].rx[j] - (crd[g].ry[j] >>> g);
					nx.ry[j] = crd[g].ry[j] + (crd[g].rx[j] >>> g);
					nx.rz[j] = crd[g].rz[j] - L'(qslerp_pkg::atan_step(g));
				end else begin
					nx.rx[j] = crd[g].rx[j] + (crd[g].ry[j] >>> g);
					nx.ry[j] = crd[g].ry[j] - (crd[g].rx[j] >>> g);
					nx.rz[j] = crd[g].rz[j] + L'(qslerp_pkg::atan_step(g));
				end
			end
		end
		qslerp_pipe #(.W($bits(cr_t))) u_p (.clk, .arst_n, .en, .vin(crv[g]),
			.din(nx), .vout(crv[g+1]), .dout(crd[g+1]));
	end

	// ---------- restoring divide, one quotient bit per stage ----------
	// numerator |sin|*2^30 < 2^62; a quotient of 2^31 or more only sets the clamp flag
	typedef struct packed {
		ctx_t x;
		logic [1:0] neg;
		logic [1:0] ovf;
		logic [1:0][63:0] rem;
		logic [1:0][DV-1:0] quo;
	} dv_t;
	dv_t dv_in;
	dv_t [DV:0] dvd;
	logic [DV:0] dvv;
	always_comb begin
		dv_in.x = crd[CORDIC_STAGES].x;
		for (int j = 0; j < 2; j++) begin
			dv_in.neg[j] = crd[CORDIC_STAGES].ry[j] < 0;
			dv_in.rem[j] = 64'(dv_in.neg[j] ? -crd[CORDIC_STAGES].ry[j]
				: crd[CORDIC_STAGES].ry[j]) << qslerp_pkg::IFRAC;
			dv_in.ovf[j] = dv_in.rem[j] >= (64'(crd[CORDIC_STAGES].x.s) << DV);
			dv_in.quo[j] = '0;
		end
	end
	assign dvd[0] = dv_in;
	assign dvv[0] = crv[CORDIC_STAGES];
	for (genvar g = 0; g < DV; g++) begin : g_dv
		dv_t nx;
		logic [63:0] dsh;
		always_comb begin
			nx = dvd[g];
			dsh = 64'(dvd[g].x.s) << (DV - 1 - g);
			for (int j = 0; j < 2; j++) begin
				nx.quo[j] = dvd[g].quo[j] << 1;
				if (dvd[g].rem[j] >= dsh) begin
					nx.rem[j] = dvd[g].rem[j] - dsh;
					nx.quo[j] = (dvd[g].quo[j] << 1) | DV'(1);
				end
			end
		end
		qslerp_pipe #(.W($bits(dv_t))) u_p (.clk, .arst_n, .en, .vin(dvv[g]),
			.din(nx), .vout(dvv[g+1]), .dout(dvd[g+1]));
	end

	// ---------- weights and mixing products ----------
	w_t k0, k1;
	logic vm;
	typedef struct packed {
		w_t [3:0] p;
		logic lin;
	} mx_t;
	mx_t mx_n, mx_s;
	ctx_t xf;
	always_comb begin
		xf = dvd[DV].x;
		// negative sine gives weight zero, oversized quotient clamps
		k0 = xf.lin ? ONE - xf.t30 : (dvd[DV].neg[0] ? '0
			: (dvd[DV].ovf[0] ? KMAX : L'(dvd[DV].quo[0])));
		k1 = xf.lin ? xf.t30 : (dvd[DV].neg[1] ? '0
			: (dvd[DV].ovf[1] ? KMAX : L'(dvd[DV].quo[1])));
		for (int i = 0; i < 4; i++)
			mx_n.p[i] = L'(xf.a[i]) * k0 + L'(xf.b[i]) * k1;
		mx_n.lin = xf.lin;
	end
	qslerp_pipe #(.W($bits(mx_t))) u_mx (.clk, .arst_n, .en, .vin(dvv[DV]),
		.din(mx_n), .vout(vm), .dout(mx_s));

	// ---------- round, saturate, output register ----------
	c_t [3:0] res;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			w_t r;
			r = (mx_s.p[i] + (L'(1) <<< (qslerp_pkg::IFRAC - 1))) >>> qslerp_pkg::IFRAC;
			if (r > ((L'(1) <<< (CW - 1)) - L'(1))) res[i] = {1'b0, {(CW-1){1'b1}}};
			else if (r < -(L'(1) <<< (CW - 1))) res[i] = {1'b1, {(CW-1){1'b0}}};
			else res[i] = CW'(r);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vm;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			{out_z, out_y, out_x, out_w} <= res;
			linear_path <= mx_s.lin;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_w))
		else $error("held item changed");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall without held item");
	a_lin: assert property (@(posedge clk) disable iff (!arst_n)
		vm && en && mx_s.lin |=> linear_path)
		else $error("linear flag lost");
`endif
endmodule
